// File: hdl/aws_pkg.sv
// Package: shared types and constants for the audio window statistics block.
package aws_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CNT_OUT_W = 18;
    localparam int Q8_W      = 24;
    localparam int SQ_W      = 31;
    localparam int MSQ_W     = 48;
    localparam int ROOT_W    = MSQ_W / 2;
    localparam int ROOT_REM_W = ROOT_W + 3;

    localparam logic [SAMPLE_W-1:0]        CLIP_RESET = 16'd32000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       last_sample;
    } t_in;

    typedef struct packed {
        logic [CNT_OUT_W-1:0]       sample_count;
        logic signed [SAMPLE_W-1:0] min_value;
        logic signed [SAMPLE_W-1:0] max_value;
        logic signed [Q8_W-1:0]     mean_q8;
        logic [Q8_W-1:0]            rms_q8;
        logic [CNT_OUT_W-1:0]       zero_count;
        logic [CNT_OUT_W-1:0]       clip_count;
    } t_out;

    typedef enum logic [2:0] {
        S_RUN,
        S_FLUSH,
        S_LDM,
        S_DIVM,
        S_DIVQ,
        S_ROOT,
        S_EMIT
    } t_state;

endpackage

// File: hdl/audio_window_statistics_top.sv
// Top level: windowed min, max, mean, RMS, zero and clip counts over PCM samples.
//
//  channel | direction | beat                 | handshake
//  in      | to block  | t_in  (sample, last) | i_in_valid / o_in_stall
//  out     | from block| t_out (window stats) | o_out_valid / i_out_stall
//  cfg     | to block  | clip threshold       | i_cfg_valid / o_cfg_ready
//
// A new sample is taken every cycle until one with the last flag is accepted;
// a last sample stalls the input through flush, load, mean divide, mean-square divide
// and root on the one shared subtractor, then emit, which waits on a stalled result.
// Reset clears accumulators and sets the threshold to 32000; no clearing pass.
// A stalled result sits in the output register; the next window may fill meanwhile.
module audio_window_statistics_top
    import aws_pkg::*;
#(
    parameter int WINDOW_MAX = 131072
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in                 i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out                o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [SAMPLE_W-1:0] i_cfg_data
);

    localparam int CW     = $clog2(WINDOW_MAX + 1);
    localparam int SW     = CW + SAMPLE_W;
    localparam int QW     = CW + SQ_W - 1;
    localparam int MDW    = SW + 8;
    localparam int QDW    = (QW + 16 > MSQ_W) ? QW + 16 : MSQ_W;
    localparam int UW     = (CW + 1 > ROOT_REM_W) ? CW + 1 : ROOT_REM_W;
    localparam int STEP_W = $clog2(QDW + 1);

    t_state r_state, n_state;

    logic [SAMPLE_W-1:0] r_thr;

    logic                       r_p_vld;
    logic signed [SAMPLE_W-1:0] r_p_s;
    logic [SQ_W-1:0]            r_p_sq;
    logic                       r_p_zero;
    logic                       r_p_clip;

    logic [CW-1:0]              r_cnt;
    logic signed [SAMPLE_W-1:0] r_min;
    logic signed [SAMPLE_W-1:0] r_max;
    logic signed [SW-1:0]       r_sum;
    logic [QW-1:0]              r_sq;
    logic [CW-1:0]              r_zero;
    logic [CW-1:0]              r_clip;

    logic [QDW-1:0]    r_dv;
    logic [UW-1:0]     r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [STEP_W-1:0] r_step;
    logic [Q8_W-1:0]   r_mean;

    logic r_out_vld;
    t_out r_out;

    logic                       in_acc;
    logic                       emit_fire;
    logic signed [SAMPLE_W-1:0] s;
    logic [SAMPLE_W:0]          mag;
    logic signed [31:0]         sq_full;
    logic                       sum_neg;
    logic [SW-1:0]              sum_mag;
    logic [MDW-1:0]             mean_dvd;

    logic           u_div;
    logic [UW-1:0]  u_a, u_b, u_diff, n_rem;
    logic           u_borrow;
    logic [QDW-1:0] n_dv;
    logic           m_last, q_last, r_last;
    logic [Q8_W-1:0] q_mean;

    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;

    // sample front end
    always_comb begin
        s       = i_in_data.sample_value;
        mag     = s[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {1'b1, s}) : {1'b0, s};
        sq_full = 32'(s) * 32'(s);
    end

    // shared subtract unit: divide step or root step
    always_comb begin
        u_div = (r_state != S_ROOT);
        if (u_div) begin
            u_a = UW'({r_rem[CW-1:0], r_dv[QDW-1]});
            u_b = UW'(r_cnt);
        end else begin
            u_a = UW'({r_rem[ROOT_REM_W-3:0], r_dv[QDW-1 -: 2]});
            u_b = UW'({r_root, 2'b01});
        end
        {u_borrow, u_diff} = {1'b0, u_a} - {1'b0, u_b};
        n_rem = u_borrow ? u_a : u_diff;
        n_dv  = u_div ? {r_dv[QDW-2:0], ~u_borrow} : {r_dv[QDW-3:0], 2'b00};
    end

    always_comb begin
        sum_neg  = r_sum[SW-1];
        sum_mag  = sum_neg ? (SW'(0) - SW'(r_sum)) : SW'(r_sum);
        mean_dvd = {sum_mag, 8'd0};
        q_mean   = n_dv[Q8_W-1:0];
        m_last   = (r_step == STEP_W'(MDW - 1));
        q_last   = (r_step == STEP_W'(QDW - 1));
        r_last   = (r_step == STEP_W'(ROOT_W - 1));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RUN:   if (in_acc && i_in_data.last_sample) n_state = S_FLUSH;
            S_FLUSH: n_state = S_LDM;
            S_LDM:   n_state = S_DIVM;
            S_DIVM:  if (m_last) n_state = S_DIVQ;
            S_DIVQ:  if (q_last) n_state = S_ROOT;
            S_ROOT:  if (r_last) n_state = S_EMIT;
            S_EMIT:  if (!r_out_vld || !i_out_stall) n_state = S_RUN;
            default: n_state = S_RUN;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = 1'b1;
        emit_fire  = 1'b0;
        unique case (r_state)
            S_RUN:   o_in_stall = 1'b0;
            S_EMIT:  emit_fire  = !r_out_vld || !i_out_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= CLIP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    // sample stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= in_acc;
        end
        if (in_acc) begin
            r_p_s    <= s;
            r_p_sq   <= sq_full[SQ_W-1:0];
            r_p_zero <= (s == '0);
            r_p_clip <= (mag >= {1'b0, r_thr});
        end
    end

    // window accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || emit_fire) begin
            r_cnt  <= '0;
            r_min  <= SAMPLE_MAX;
            r_max  <= SAMPLE_MIN;
            r_sum  <= '0;
            r_sq   <= '0;
            r_zero <= '0;
            r_clip <= '0;
        end else if (r_p_vld && (r_cnt < CW'(WINDOW_MAX))) begin
            r_cnt  <= r_cnt + CW'(1);
            if (r_p_s < r_min) r_min <= r_p_s;
            if (r_p_s > r_max) r_max <= r_p_s;
            r_sum  <= r_sum + SW'(r_p_s);
            r_sq   <= r_sq + QW'(r_p_sq);
            r_zero <= r_zero + CW'(r_p_zero);
            r_clip <= r_clip + CW'(r_p_clip);
        end
    end

    // divide and root sequencing
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LDM: begin
                r_dv   <= QDW'(mean_dvd) << (QDW - MDW);
                r_rem  <= '0;
                r_step <= '0;
            end
            S_DIVM: begin
                r_dv   <= n_dv;
                r_rem  <= n_rem;
                r_step <= r_step + STEP_W'(1);
                if (m_last) begin
                    r_mean <= sum_neg ? (Q8_W'(0) - q_mean) : q_mean;
                    r_dv   <= QDW'({r_sq, 16'd0});
                    r_rem  <= '0;
                    r_step <= '0;
                end
            end
            S_DIVQ: begin
                r_dv   <= n_dv;
                r_rem  <= n_rem;
                r_step <= r_step + STEP_W'(1);
                if (q_last) begin
                    r_dv   <= QDW'(n_dv[MSQ_W-1:0]) << (QDW - MSQ_W);
                    r_rem  <= '0;
                    r_root <= '0;
                    r_step <= '0;
                end
            end
            S_ROOT: begin
                r_dv   <= n_dv;
                r_rem  <= n_rem;
                r_root <= {r_root[ROOT_W-2:0], ~u_borrow};
                r_step <= r_step + STEP_W'(1);
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit_fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
        if (emit_fire) begin
            r_out.sample_count <= CNT_OUT_W'(r_cnt);
            r_out.min_value    <= r_min;
            r_out.max_value    <= r_max;
            r_out.mean_q8      <= r_mean;
            r_out.rms_q8       <= r_root;
            r_out.zero_count   <= CNT_OUT_W'(r_zero);
            r_out.clip_count   <= CNT_OUT_W'(r_clip);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.last_sample |=> o_in_stall)
        else $error("input taken after last sample of window");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(WINDOW_MAX))
        else $error("sample count beyond window bound");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVM || r_state == S_DIVQ) |-> (r_rem < UW'(r_cnt)))
        else $error("divider remainder not below count");

    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_EMIT))
        else $error("result raised outside emit");
`endif

endmodule

// File: tb/sv/testbench.sv
// Testbench for audio_window_statistics_top: windowed PCM statistics checked beat by beat.
`timescale 1ns / 1ps

module testbench
    import aws_pkg::*;
();

    localparam int WINDOW_MAX     = 131072;
    localparam int SETTLE_CYCLES  = 200;
    localparam int HOLD_CYCLES    = 500;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                in_valid    = 1'b0;
    t_in                 in_data     = '0;
    logic                out_stall   = 1'b0;
    logic                cfg_valid   = 1'b0;
    logic [SAMPLE_W-1:0] cfg_data    = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    t_out                o_out_data;
    logic                o_cfg_ready;

    t_in  sample_feed[$];
    t_out stats_due[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_arm      = 1'b0;
    int hold_left     = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    // window accumulators of the predictor
    int              threshold;
    int              win_count;
    int              win_min;
    int              win_max;
    longint          win_sum;
    longint unsigned win_sq;
    int              win_zero;
    int              win_clip;

    audio_window_statistics_top #(
        .WINDOW_MAX(WINDOW_MAX)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void clear_window();
        win_count = 0;
        win_min   = 32767;
        win_max   = -32768;
        win_sum   = 0;
        win_sq    = 0;
        win_zero  = 0;
        win_clip  = 0;
    endfunction

    function automatic void fold_sample(t_in d);
        int              s;
        int              mag;
        longint          n;
        longint          mean;
        longint unsigned q;
        longint unsigned r;
        longint unsigned msq;
        longint unsigned root;
        longint unsigned trial;
        t_out            res;
        s = int'($signed(d.sample_value));
        if (win_count < WINDOW_MAX) begin
            mag = (s < 0) ? -s : s;
            win_count++;
            if (s < win_min) win_min = s;
            if (s > win_max) win_max = s;
            win_sum += s;
            win_sq  += longint'(mag * mag);
            if (s == 0) win_zero++;
            if (mag >= threshold) win_clip++;
        end
        if (d.last_sample) begin
            n    = win_count;
            mean = (win_sum * 256) / n;
            q    = win_sq / n;
            r    = win_sq % n;
            msq  = q * 65536 + (r * 65536) / n;
            root = 0;
            for (int b = 24; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= msq) root = trial;
            end
            res.sample_count = n[CNT_OUT_W-1:0];
            res.min_value    = win_min[SAMPLE_W-1:0];
            res.max_value    = win_max[SAMPLE_W-1:0];
            res.mean_q8      = mean[Q8_W-1:0];
            res.rms_q8       = root[Q8_W-1:0];
            res.zero_count   = win_zero[CNT_OUT_W-1:0];
            res.clip_count   = win_clip[CNT_OUT_W-1:0];
            stats_due.push_back(res);
            clear_window();
        end
    endfunction

    task automatic compare_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                fold_sample(in_data);
            end
            if (!in_valid || !o_in_stall) begin
                if (sample_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_data  <= sample_feed.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (stats_due.size() == 0) begin
                    $error("result beat with no expectation pending");
                    mismatches++;
                end else begin
                    want = stats_due.pop_front();
                    compare_field("sample_count", want.sample_count, o_out_data.sample_count);
                    compare_field("min_value", want.min_value, o_out_data.min_value);
                    compare_field("max_value", want.max_value, o_out_data.max_value);
                    compare_field("mean_q8", want.mean_q8, o_out_data.mean_q8);
                    compare_field("rms_q8", want.rms_q8, o_out_data.rms_q8);
                    compare_field("zero_count", want.zero_count, o_out_data.zero_count);
                    compare_field("clip_count", want.clip_count, o_out_data.clip_count);
                end
            end
            if (hold_arm) begin
                hold_arm  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void push_beat(int value, bit last);
        t_in d;
        d.sample_value = value[SAMPLE_W-1:0];
        d.last_sample  = last;
        sample_feed.push_back(d);
    endfunction

    function automatic int pick_sample();
        int pick;
        int t;
        pick = $urandom_range(99);
        if (pick < 8) return -32768;
        if (pick < 16) return 32767;
        if (pick < 26) return 0;
        if (pick < 46) begin
            t = threshold + int'($urandom_range(2)) - 1;
            if (t < 0) t = 0;
            if (t > 32768) t = 32768;
            if ($urandom_range(1)) t = -t;
            if (t > 32767) t = 32767;
            return t;
        end
        if (pick < 56) return int'($urandom_range(6)) - 3;
        return int'($signed(16'($urandom)));
    endfunction

    function automatic int push_window(int len);
        for (int i = 0; i < len; i++) begin
            push_beat(pick_sample(), i == len - 1);
        end
        return len;
    endfunction

    task automatic drain();
        while (sample_feed.size() != 0 || in_valid || stats_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_threshold(int v);
        @(posedge i_clk);
        cfg_data  <= v[SAMPLE_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        threshold = v;
    endtask

    task automatic run_phase(int thr, int send_pct, int stall_p, int items, bit squeeze);
        int pushed;
        int pick;
        int len;
        drain();
        write_threshold(thr);
        @(negedge i_clk);
        send_idle_pct = send_pct;
        stall_pct     = stall_p;
        if (squeeze) hold_arm = 1'b1;
        pushed = 0;
        while (pushed < items) begin
            pick = $urandom_range(99);
            if (squeeze) len = $urandom_range(4, 1);
            else if (pick < 70) len = $urandom_range(12, 1);
            else if (pick < 95) len = $urandom_range(80, 13);
            else len = $urandom_range(300, 81);
            pushed += push_window(len);
        end
    endtask

    initial begin
        threshold = int'(CLIP_RESET);
        clear_window();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single-sample windows at the extremes
        push_beat(-32768, 1'b1);
        push_beat(32767, 1'b1);
        push_beat(0, 1'b1);
        // both sides of the reset clip threshold
        push_beat(32767, 1'b0);
        push_beat(-32768, 1'b0);
        push_beat(0, 1'b0);
        push_beat(1, 1'b0);
        push_beat(-1, 1'b0);
        push_beat(31999, 1'b0);
        push_beat(32000, 1'b0);
        push_beat(-32000, 1'b0);
        push_beat(-31999, 1'b1);
        // negative mean truncates towards zero
        push_beat(-1, 1'b0);
        push_beat(0, 1'b0);
        push_beat(0, 1'b1);
        push_beat(-32768, 1'b0);
        push_beat(-32768, 1'b1);
        push_beat(5, 1'b0);
        push_beat(-5, 1'b1);
        drain();

        run_phase(0, 78, 0, 200, 1'b0);
        run_phase(32768, 0, 78, 200, 1'b0);
        run_phase($urandom_range(32767, 1), 35, 35, 200, 1'b0);
        run_phase(32767, 0, 0, 150, 1'b1);
        run_phase(1, 0, 0, 150, 1'b0);
        run_phase(int'(CLIP_RESET), 35, 35, 100, 1'b0);
        drain();

        if (mismatches == 0 && stats_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
